// File: hw/rtl/three_thruster_mixer_with_spin_limit_macros.svh
// Assertion macros shared by the mixer RTL
`ifndef THREE_THRUSTER_MIXER_WITH_SPIN_LIMIT_MACROS_SVH
`define THREE_THRUSTER_MIXER_WITH_SPIN_LIMIT_MACROS_SVH
`ifndef ASSERT_OFF
`define TTM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TTM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TTM_ASSERT(lbl, clk, rst, prop, msg)
`define TTM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/ttm_pkg.sv
// Shared constants and types for the three-thruster mixer
package ttm_pkg;

  localparam int FRAC_BITS = 15;
  localparam logic [15:0] THRUST_ONE = 16'(1 << FRAC_BITS);

  // 1/sqrt3 in Q0.16
  localparam logic [15:0] K_INV_SQRT3 = 16'd37837;

  localparam logic [1:0] CMD_STICK = 2'd0;
  localparam logic [1:0] CMD_GYRO  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_BRAKE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BRAKE = 3'd4;

  typedef struct packed {
    logic [14:0]        dead_zone;
    logic signed [15:0] left_rate_limit;
    logic signed [15:0] right_rate_limit;
    logic [15:0]        left_brake_thrust;
    logic [15:0]        right_brake_thrust;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         command;
    logic               power_on;
    logic signed [15:0] x_axis;
    logic signed [15:0] y_axis;
    logic signed [15:0] spin_axis;
    logic signed [15:0] lift_level;
    logic               red_request;
    logic               green_request;
    logic signed [15:0] gyro_sample;
  } item_t;

  typedef struct packed {
    logic [15:0] back;
    logic [15:0] right;
    logic [15:0] left;
    logic [15:0] spin_right;
    logic [15:0] spin_left;
    logic        rot_pos;
    logic        rot_neg;
  } mix_t;

  typedef struct packed {
    logic signed [15:0] lift;
    logic [15:0]        back;
    logic [15:0]        right;
    logic [15:0]        left;
    logic [15:0]        spin_right;
    logic [15:0]        spin_left;
  } held_t;

endpackage

// File: hw/rtl/ttm_ifs.sv
// Valid/ready channel interfaces for command items and thrust results
interface ttm_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic               power_on;
  logic signed [15:0] x_axis;
  logic signed [15:0] y_axis;
  logic signed [15:0] spin_axis;
  logic signed [15:0] lift_level;
  logic               red_request;
  logic               green_request;
  logic signed [15:0] gyro_sample;

  modport source(output valid, command, power_on, x_axis, y_axis, spin_axis, lift_level,
                 red_request, green_request, gyro_sample, input ready);
  modport sink(input valid, command, power_on, x_axis, y_axis, spin_axis, lift_level,
               red_request, green_request, gyro_sample, output ready);
endinterface

interface ttm_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] lift_out;
  logic [15:0]        back_thrust;
  logic [15:0]        right_thrust;
  logic [15:0]        left_thrust;
  logic [15:0]        spin_right_out;
  logic [15:0]        spin_left_out;
  logic               red_led;
  logic               grn_led;
  logic               led_valid;

  modport source(output valid, lift_out, back_thrust, right_thrust, left_thrust,
                 spin_right_out, spin_left_out, red_led, grn_led, led_valid, input ready);
  modport sink(input valid, lift_out, back_thrust, right_thrust, left_thrust,
               spin_right_out, spin_left_out, red_led, grn_led, led_valid, output ready);
endinterface

// File: hw/rtl/ttm_cfg.sv
// Configuration register file with a plain write port
module ttm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ttm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttm_pkg::CFG_DATA_W-1:0] cfg_data,
  output ttm_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone          <= 15'd4915;
      cfg.left_rate_limit    <= 16'sd569;
      cfg.right_rate_limit   <= -16'sd313;
      cfg.left_brake_thrust  <= 16'd3277;
      cfg.right_brake_thrust <= 16'd24576;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttm_pkg::REG_DEAD_ZONE:   cfg.dead_zone          <= cfg_data[14:0];
        ttm_pkg::REG_LEFT_LIMIT:  cfg.left_rate_limit    <= $signed(cfg_data);
        ttm_pkg::REG_RIGHT_LIMIT: cfg.right_rate_limit   <= $signed(cfg_data);
        ttm_pkg::REG_LEFT_BRAKE:  cfg.left_brake_thrust  <= cfg_data;
        ttm_pkg::REG_RIGHT_BRAKE: cfg.right_brake_thrust <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/ttm_mix.sv
// Stick dead zone, angle sector, three-thruster translation mix and spin direction split
module ttm_mix (
  input  logic signed [15:0] x_axis,
  input  logic signed [15:0] y_axis,
  input  logic signed [15:0] spin_axis,
  input  logic [14:0]        dead_zone,
  output ttm_pkg::mix_t      mix
);

  function automatic logic [15:0] sat01(input logic signed [19:0] v);
    logic [15:0] r;
    if (v < 0)
      r = '0;
    else if (v > $signed({4'b0, ttm_pkg::THRUST_ONE}))
      r = ttm_pkg::THRUST_ONE;
    else
      r = v[15:0];
    return r;
  endfunction

  logic signed [16:0] x, y, r;
  logic [16:0]        ax, ay, ar, dz;
  logic               active, keep_rot;
  logic [33:0]        x2, y2;
  logic [35:0]        y3, x2w;
  logic               sec_a, sec_b;
  logic [32:0]        prod;
  logic [33:0]        rnd1, rnd2;
  logic signed [19:0] p1, p2, mk1, mk2, y20;
  logic signed [19:0] a, b, c;

  always_comb begin
    x  = -{x_axis[15], x_axis};       // x is negated; -(-32768) still fits
    y  = {y_axis[15], y_axis};
    r  = {spin_axis[15], spin_axis};
    ax = x[16] ? 17'(-x) : 17'(x);
    ay = y[16] ? 17'(-y) : 17'(y);
    ar = r[16] ? 17'(-r) : 17'(r);
    dz = {2'b0, dead_zone};
    active   = (ax > dz) || (ay > dz);
    keep_rot = ar > dz;

    // sector boundaries at 210 and 330 degrees: compare 3*y^2 against x^2
    x2  = ax * ax;
    y2  = ay * ay;
    y3  = {2'b0, y2} + {1'b0, y2, 1'b0};
    x2w = {2'b0, x2};
    sec_a = (x <= 0 && y >= 0) || (x < 0 && y < 0 && y3 < x2w);
    sec_b = (y < 0) && ((x == 0) || (x < 0 && y3 >= x2w) || (x > 0 && y3 > x2w));

    // |x|/sqrt3 and 2|x|/sqrt3 from one product, rounded half away from zero
    prod = ax * ttm_pkg::K_INV_SQRT3;
    rnd1 = {1'b0, prod} + 34'd32768;
    rnd2 = {prod, 1'b0} + 34'd32768;
    p1   = $signed({2'b0, rnd1[33:16]});
    p2   = $signed({2'b0, rnd2[33:16]});
    mk1  = x[16] ? -p1 : p1;
    mk2  = x[16] ? -p2 : p2;
    y20  = {{3{y[16]}}, y};

    a = '0;
    b = '0;
    c = '0;
    if (active) begin
      if (sec_a) begin
        // x <= 0 here, so the -x terms are the plain magnitudes
        b = p2;
        a = y20 + p1;
      end else if (sec_b) begin
        c = mk1 - y20;
        b = -y20 - mk1;
      end else begin
        c = mk2;
        a = y20 + mk1;
      end
    end

    mix.back       = sat01(a);
    mix.right      = sat01(b);
    mix.left       = sat01(c);
    mix.rot_pos    = keep_rot && !r[16];
    mix.rot_neg    = keep_rot && r[16];
    mix.spin_right = mix.rot_pos ? r[15:0] : '0;
    mix.spin_left  = mix.rot_neg ? ar[15:0] : '0;
  end

endmodule

// File: hw/rtl/three_thruster_mixer_with_spin_limit.sv
// Three-thruster mixer: accepts one item per cycle while not stalled; an accepted item passes
// the input register, then the mix into the held-state and result registers.
// The one path between them holds a 17x16 constant product and two narrow squarers for
// the sector test. Stick commands always give a result; gyro samples never do; a control
// tick gives one while either turn flag is set, and otherwise only to clear leftover
// spin. The block stalls only while the result register is full and not taken.
module three_thruster_mixer_with_spin_limit (
  input  logic                           clk,
  input  logic                           rst,
  ttm_item_if.sink                       item,
  ttm_result_if.source                   result,
  input  logic                           cfg_we,
  input  logic [ttm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttm_pkg::CFG_DATA_W-1:0] cfg_data
);

  `include "three_thruster_mixer_with_spin_limit_macros.svh"

  ttm_pkg::cfg_t  cfg;
  ttm_pkg::mix_t  mix;
  ttm_pkg::item_t iq;
  logic           iq_valid;
  logic           advance;

  ttm_pkg::held_t     held, held_next;
  logic               turning_left, turning_left_next;
  logic               turning_right, turning_right_next;
  logic signed [15:0] gyro_rate, gyro_rate_next;
  logic               emit, red_next, green_next, led_valid_next;

  ttm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ttm_mix u_mix (
    .x_axis    (iq.x_axis),
    .y_axis    (iq.y_axis),
    .spin_axis (iq.spin_axis),
    .dead_zone (cfg.dead_zone),
    .mix       (mix)
  );

  assign advance    = iq_valid && (!result.valid || result.ready);
  assign item.ready = !iq_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (item.ready) begin
      iq_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      iq.command       <= item.command;
      iq.power_on      <= item.power_on;
      iq.x_axis        <= item.x_axis;
      iq.y_axis        <= item.y_axis;
      iq.spin_axis     <= item.spin_axis;
      iq.lift_level    <= item.lift_level;
      iq.red_request   <= item.red_request;
      iq.green_request <= item.green_request;
      iq.gyro_sample   <= item.gyro_sample;
    end
  end

  always_comb begin
    held_next          = held;
    turning_left_next  = turning_left;
    turning_right_next = turning_right;
    gyro_rate_next     = gyro_rate;
    emit               = 1'b0;
    red_next           = 1'b0;
    green_next         = 1'b0;
    led_valid_next     = 1'b0;
    unique case (iq.command)
      ttm_pkg::CMD_STICK: begin
        emit           = 1'b1;
        led_valid_next = 1'b1;
        held_next      = '0;
        if (iq.power_on) begin
          held_next.lift       = iq.lift_level;
          held_next.back       = mix.back;
          held_next.right      = mix.right;
          held_next.left       = mix.left;
          held_next.spin_right = mix.spin_right;
          held_next.spin_left  = mix.spin_left;
          turning_left_next    = mix.rot_pos;
          turning_right_next   = mix.rot_neg;
          red_next             = iq.red_request;
          green_next           = iq.green_request;
        end
      end
      ttm_pkg::CMD_GYRO: begin
        gyro_rate_next = iq.gyro_sample;
      end
      ttm_pkg::CMD_TICK: begin
        if (turning_left) begin
          emit = 1'b1;
          held_next.spin_left = (gyro_rate > cfg.left_rate_limit) ?
                                cfg.left_brake_thrust : '0;
        end else if (turning_right) begin
          emit = 1'b1;
          held_next.spin_right = (gyro_rate < cfg.right_rate_limit) ?
                                 cfg.right_brake_thrust : '0;
        end else if (held.spin_right != '0 || held.spin_left != '0) begin
          // spin left over with neither turn flag set is cleared once
          emit = 1'b1;
          held_next.spin_right = '0;
          held_next.spin_left  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held          <= '0;
      turning_left  <= 1'b0;
      turning_right <= 1'b0;
      gyro_rate     <= '0;
    end else if (advance) begin
      held          <= held_next;
      turning_left  <= turning_left_next;
      turning_right <= turning_right_next;
      gyro_rate     <= gyro_rate_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance && emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result.lift_out       <= held_next.lift;
      result.back_thrust    <= held_next.back;
      result.right_thrust   <= held_next.right;
      result.left_thrust    <= held_next.left;
      result.spin_right_out <= held_next.spin_right;
      result.spin_left_out  <= held_next.spin_left;
      result.red_led        <= red_next;
      result.grn_led        <= green_next;
      result.led_valid      <= led_valid_next;
    end
  end

  `TTM_ASSERT(a_turn_exclusive, clk, rst, !(turning_left && turning_right), "both turning flags set")
  `TTM_ASSERT(a_leds_need_stick, clk, rst, !(result.valid && !result.led_valid && (result.red_led || result.grn_led)), "LED set on tick result")
  `TTM_ASSERT(a_thrust_range, clk, rst, !(result.valid && (result.back_thrust > ttm_pkg::THRUST_ONE || result.right_thrust > ttm_pkg::THRUST_ONE || result.left_thrust > ttm_pkg::THRUST_ONE)), "translation thrust above 1.0")
  `TTM_ASSERT_NEXT(a_input_held, clk, rst, iq_valid && !advance, iq_valid, "input register dropped a stalled item")

endmodule

// File: tb/three_thruster_mixer_with_spin_limit_tb.sv
// Self-checking testbench for the three-thruster mixer with spin-rate brake
module three_thruster_mixer_with_spin_limit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] lift;
    logic [15:0] back;
    logic [15:0] right;
    logic [15:0] left;
    logic [15:0] spin_right;
    logic [15:0] spin_left;
    logic        red;
    logic        green;
    logic        led_valid;
  } thrust_msg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ttm_item_if   item_ch ();
  ttm_result_if result_ch ();

  three_thruster_mixer_with_spin_limit u_top (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the block's registers and state
  cfg_t               cfg;
  held_t              held;
  logic signed [15:0] gyro_rate;
  bit                 turn_left;
  bit                 turn_right;

  item_t       cmd_backlog[$];
  thrust_msg_t thrust_msgs_due[$];
  int          issued_count = 0;
  int          accepted_count = 0;
  int          fault_count = 0;
  bit          offer_open = 0;
  bit          no_idle = 0;

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // v * k / 2^16, rounded half away from zero
  function automatic longint scale_q16(input longint v, input longint k);
    longint p;
    p = (mag(v) * k + 64'sd32768) >>> 16;
    return (v < 0) ? -p : p;
  endfunction

  function automatic logic [15:0] clamp_unit(input longint v);
    if (v < 0) return 16'd0;
    if (v > 32768) return THRUST_ONE;
    return v[15:0];
  endfunction

  function automatic bit predict_thrusters(input item_t c, output thrust_msg_t m);
    longint x, y, r, dz, a, b, lt, x2, y3;
    bit in_a, in_b, produced;
    m = '0;
    produced = 0;
    case (c.command)
      CMD_STICK: begin
        held = '0;
        if (c.power_on) begin
          x = -longint'(c.x_axis);
          y = longint'(c.y_axis);
          r = longint'(c.spin_axis);
          dz = longint'(cfg.dead_zone);
          a = 0;
          b = 0;
          lt = 0;
          if (mag(r) <= dz) r = 0;
          if (mag(x) > dz || mag(y) > dz) begin
            x2 = x * x;
            y3 = 3 * y * y;
            in_a = (x <= 0 && y >= 0) || (x < 0 && y < 0 && y3 < x2);
            in_b = (y < 0) && (x == 0 || (x < 0 && y3 >= x2) || (x > 0 && y3 > x2));
            if (in_a) begin
              b = scale_q16(-x, 75674);
              a = y + scale_q16(-x, 37837);
            end else if (in_b) begin
              lt = scale_q16(x, 37837) - y;
              b = -y - scale_q16(x, 37837);
            end else begin
              lt = scale_q16(x, 75674);
              a = y + scale_q16(x, 37837);
            end
          end
          held.back = clamp_unit(a);
          held.right = clamp_unit(b);
          held.left = clamp_unit(lt);
          held.lift = c.lift_level;
          if (r > 0) begin
            held.spin_right = r[15:0];
            turn_left = 1;
            turn_right = 0;
          end else if (r < 0) begin
            held.spin_left = 16'((-r));
            turn_right = 1;
            turn_left = 0;
          end else begin
            turn_left = 0;
            turn_right = 0;
          end
          m.red = c.red_request;
          m.green = c.green_request;
        end
        m.led_valid = 1'b1;
        produced = 1;
      end
      CMD_GYRO: gyro_rate = c.gyro_sample;
      CMD_TICK: begin
        produced = 1;
        if (turn_left)
          held.spin_left = (gyro_rate > cfg.left_rate_limit) ? cfg.left_brake_thrust : 16'd0;
        else if (turn_right)
          held.spin_right = (gyro_rate < cfg.right_rate_limit) ? cfg.right_brake_thrust : 16'd0;
        else if (held.spin_right != 0 || held.spin_left != 0)
          held.spin_right = 16'd0;
        else
          produced = 0;
        if (!turn_left && !turn_right) held.spin_left = 16'd0;
      end
      default: ;
    endcase
    if (produced) begin
      m.lift = held.lift;
      m.back = held.back;
      m.right = held.right;
      m.left = held.left;
      m.spin_right = held.spin_right;
      m.spin_left = held.spin_left;
    end
    return produced;
  endfunction

  // Command driver: once valid is raised it holds until the transaction completes
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!offer_open) begin
      if (cmd_backlog.size() != 0 && (no_idle || $urandom_range(0, 99) >= 17)) begin
        item_ch.valid <= 1'b1;
        item_ch.command <= cmd_backlog[0].command;
        item_ch.power_on <= cmd_backlog[0].power_on;
        item_ch.x_axis <= cmd_backlog[0].x_axis;
        item_ch.y_axis <= cmd_backlog[0].y_axis;
        item_ch.spin_axis <= cmd_backlog[0].spin_axis;
        item_ch.lift_level <= cmd_backlog[0].lift_level;
        item_ch.red_request <= cmd_backlog[0].red_request;
        item_ch.green_request <= cmd_backlog[0].green_request;
        item_ch.gyro_sample <= cmd_backlog[0].gyro_sample;
        offer_open = 1;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    thrust_msg_t m;
    if (!rst && item_ch.valid && item_ch.ready) begin
      if (predict_thrusters(cmd_backlog[0], m)) thrust_msgs_due.push_back(m);
      cmd_backlog.pop_front();
      offer_open = 0;
      accepted_count++;
    end
  end

  always @(negedge clk) begin
    result_ch.ready <= !rst && (no_idle || $urandom_range(0, 99) >= 17);
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    thrust_msg_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (thrust_msgs_due.size() == 0) begin
        $display("%0t: result with no pending transaction", $time);
        fault_count++;
      end else begin
        want = thrust_msgs_due.pop_front();
        compare_field("lift_out", want.lift, result_ch.lift_out);
        compare_field("back_thrust", want.back, result_ch.back_thrust);
        compare_field("right_thrust", want.right, result_ch.right_thrust);
        compare_field("left_thrust", want.left, result_ch.left_thrust);
        compare_field("spin_right_out", want.spin_right, result_ch.spin_right_out);
        compare_field("spin_left_out", want.spin_left, result_ch.spin_left_out);
        compare_field("red_led", 16'(want.red), 16'(result_ch.red_led));
        compare_field("grn_led", 16'(want.green), 16'(result_ch.grn_led));
        compare_field("led_valid", 16'(want.led_valid), 16'(result_ch.led_valid));
      end
    end
  end

  task automatic send_cmd(input item_t c);
    int ticket;
    ticket = issued_count;
    issued_count++;
    cmd_backlog.push_back(c);
    wait (accepted_count > ticket);
  endtask

  task automatic hold_until_results_drained();
    while (cmd_backlog.size() != 0 || thrust_msgs_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_DEAD_ZONE:   cfg.dead_zone = data[14:0];
      REG_LEFT_LIMIT:  cfg.left_rate_limit = data;
      REG_RIGHT_LIMIT: cfg.right_rate_limit = data;
      REG_LEFT_BRAKE:  cfg.left_brake_thrust = data;
      REG_RIGHT_BRAKE: cfg.right_brake_thrust = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Gyro samples and quiet ticks leave no result, so give the pipe time to empty
  task automatic load_config(input logic [15:0] dz, input logic [15:0] l_lim,
                             input logic [15:0] r_lim, input logic [15:0] l_brk,
                             input logic [15:0] r_brk);
    hold_until_results_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_DEAD_ZONE, dz);
    write_reg(REG_LEFT_LIMIT, l_lim);
    write_reg(REG_RIGHT_LIMIT, r_lim);
    write_reg(REG_LEFT_BRAKE, l_brk);
    write_reg(REG_RIGHT_BRAKE, r_brk);
  endtask

  function automatic item_t noise_cmd();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t stick_cmd(input bit pwr, input logic [15:0] x,
                                      input logic [15:0] y, input logic [15:0] spin,
                                      input logic [15:0] lift, input bit red,
                                      input bit green);
    item_t c;
    c = noise_cmd();
    c.command = CMD_STICK;
    c.power_on = pwr;
    c.x_axis = x;
    c.y_axis = y;
    c.spin_axis = spin;
    c.lift_level = lift;
    c.red_request = red;
    c.green_request = green;
    return c;
  endfunction

  function automatic item_t gyro_cmd(input logic [15:0] g);
    item_t c;
    c = noise_cmd();
    c.command = CMD_GYRO;
    c.gyro_sample = g;
    return c;
  endfunction

  function automatic item_t tick_cmd();
    item_t c;
    c = noise_cmd();
    c.command = CMD_TICK;
    return c;
  endfunction

  function automatic logic [15:0] pick_axis();
    int t;
    case ($urandom_range(0, 3))
      0: t = $urandom;
      1: begin
        t = int'(cfg.dead_zone) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) t = -t;
      end
      2: case ($urandom_range(0, 3))
        0: t = 32'h8000;
        1: t = 32'h7fff;
        2: t = 0;
        default: t = 32'h8001;
      endcase
      default: begin
        t = $urandom_range(0, 2000);
        if ($urandom_range(0, 1)) t = -t;
      end
    endcase
    return t[15:0];
  endfunction

  function automatic logic [15:0] pick_rate();
    int t;
    case ($urandom_range(0, 2))
      0: t = $urandom;
      1: t = int'(cfg.left_rate_limit) + int'($urandom_range(0, 2)) - 1;
      default: t = int'(cfg.right_rate_limit) + int'($urandom_range(0, 2)) - 1;
    endcase
    return t[15:0];
  endfunction

  function automatic item_t random_stick();
    return stick_cmd($urandom_range(0, 9) != 0, pick_axis(), pick_axis(), pick_axis(),
                     16'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // Mostly turn maneuvers: a stick command, then gyro samples and ticks
  task automatic run_random_traffic(input int count);
    int sent;
    int steps;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 80) begin
        send_cmd(random_stick());
        sent++;
        steps = $urandom_range(1, 4);
        repeat (steps) begin
          if ($urandom_range(0, 1)) begin
            send_cmd(gyro_cmd(pick_rate()));
            sent++;
          end
          send_cmd(tick_cmd());
          sent++;
        end
      end else begin
        send_cmd(noise_cmd());
        sent++;
      end
      if ($urandom_range(0, 39) == 0) hold_until_results_drained();
    end
  endtask

  task automatic test_power_and_extremes();
    send_cmd(stick_cmd(0, 16'h7fff, 16'h8000, 16'h7fff, 16'h1234, 1, 1));
    send_cmd(stick_cmd(1, 16'h8000, 16'h0000, 16'h7fff, 16'h8000, 1, 0));
    send_cmd(stick_cmd(1, 16'h7fff, 16'h0000, 16'h8000, 16'h7fff, 0, 1));
    send_cmd(stick_cmd(1, 16'h0000, 16'h7fff, 16'h0000, 16'hffff, 1, 1));
    send_cmd(stick_cmd(1, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 0, 0));
    send_cmd(stick_cmd(1, 16'h8000, 16'h8000, 16'h8000, 16'h0001, 1, 0));
  endtask

  task automatic test_dead_zone_edges();
    send_cmd(stick_cmd(1, 16'd4915, 16'd4915, 16'd4915, 16'h4000, 0, 1));
    send_cmd(stick_cmd(1, -16'sd4915, -16'sd4915, -16'sd4915, 16'h4000, 1, 1));
    send_cmd(stick_cmd(1, -16'sd4916, 16'd0, 16'd4916, 16'h0100, 0, 0));
    send_cmd(stick_cmd(1, 16'd0, 16'd4916, -16'sd4916, 16'h0200, 1, 0));
  endtask

  // Lower sector borders sit on the lines y = -|x|/sqrt3
  task automatic test_sector_edges();
    send_cmd(stick_cmd(1, -16'sd17320, -16'sd10000, 16'd0, 16'd0, 0, 0));
    send_cmd(stick_cmd(1, -16'sd17321, -16'sd10000, 16'd0, 16'd0, 0, 0));
    send_cmd(stick_cmd(1, 16'd17320, -16'sd10000, 16'd0, 16'd0, 0, 0));
    send_cmd(stick_cmd(1, 16'd17321, -16'sd10000, 16'd0, 16'd0, 0, 0));
  endtask

  task automatic test_spin_brake();
    send_cmd(tick_cmd());
    send_cmd(stick_cmd(1, 16'd0, 16'd0, 16'd20000, 16'd0, 0, 0));
    send_cmd(gyro_cmd(16'h7fff));
    send_cmd(tick_cmd());
    send_cmd(gyro_cmd(16'h8000));
    send_cmd(tick_cmd());
    send_cmd(stick_cmd(1, 16'd0, 16'd0, -16'sd20000, 16'd0, 1, 1));
    send_cmd(tick_cmd());
    send_cmd(gyro_cmd(16'h7fff));
    send_cmd(tick_cmd());
    // power off keeps the turn flag, so the next tick still brakes
    send_cmd(stick_cmd(0, 16'd0, 16'd0, 16'd0, 16'd0, 1, 1));
    send_cmd(gyro_cmd(16'h8000));
    send_cmd(tick_cmd());
  endtask

  task automatic test_ignored_command();
    item_t c;
    c = noise_cmd();
    c.command = CMD_UNUSED;
    send_cmd(c);
    send_cmd(tick_cmd());
  endtask

  task automatic test_cfg_low_extremes();
    load_config(16'd0, 16'h8000, 16'h7fff, 16'h8000, 16'h0000);
    run_random_traffic(175);
  endtask

  task automatic test_cfg_high_extremes();
    load_config(16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'h8000);
    run_random_traffic(175);
  endtask

  task automatic test_cfg_random_back_to_back();
    load_config(16'($urandom_range(0, 8000)), 16'($urandom), 16'($urandom),
                16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)));
    no_idle = 1;
    run_random_traffic(175);
    no_idle = 0;
  endtask

  task automatic test_cfg_defaults();
    load_config(16'd4915, 16'd569, -16'sd313, 16'd3277, 16'd24576);
    run_random_traffic(175);
  endtask

  initial begin
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.command = CMD_STICK;
    item_ch.power_on = 1'b0;
    item_ch.x_axis = '0;
    item_ch.y_axis = '0;
    item_ch.spin_axis = '0;
    item_ch.lift_level = '0;
    item_ch.red_request = 1'b0;
    item_ch.green_request = 1'b0;
    item_ch.gyro_sample = '0;
    result_ch.ready = 1'b0;
    cfg.dead_zone = 15'd4915;
    cfg.left_rate_limit = 16'sd569;
    cfg.right_rate_limit = -16'sd313;
    cfg.left_brake_thrust = 16'd3277;
    cfg.right_brake_thrust = 16'd24576;
    held = '0;
    gyro_rate = '0;
    turn_left = 0;
    turn_right = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_power_and_extremes();
    test_dead_zone_edges();
    test_sector_edges();
    test_spin_brake();
    test_ignored_command();
    test_cfg_low_extremes();
    test_cfg_high_extremes();
    test_cfg_random_back_to_back();
    test_cfg_defaults();

    hold_until_results_drained();
    repeat (10) @(posedge clk);
    if (fault_count == 0)
      $display("[three_thruster_mixer_with_spin_limit] OK");
    else
      $display("[three_thruster_mixer_with_spin_limit] ERROR");
    $finish;
  end

  initial begin
    #400000;
    $display("%0t: timeout", $time);
    $display("[three_thruster_mixer_with_spin_limit] ERROR");
    $finish;
  end

endmodule
